FILE: design/graph_reachability_engine_core_defines.svh
// assertion macros for the graph reachability engine
`ifndef GRAPH_REACHABILITY_ENGINE_CORE_DEFINES_SVH
`define GRAPH_REACHABILITY_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define GRE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define GRE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define GRE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GRE_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: design/gre_pkg.sv
// shared types and constants of the graph reachability engine
`timescale 1ns / 1ps

package gre_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned NODE_W = 3;
  localparam int unsigned IN_W   = 8;
  localparam int unsigned OUT_W  = 8;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;
  localparam logic [MODE_W-1:0] MODE_VISIT = 2'd3;

  // input item, lowest field last
  typedef struct packed {
    logic [NODE_W-1:0] target;
    logic [NODE_W-1:0] source;
    logic [MODE_W-1:0] mode;
  } in_t;

  // result payload, lowest field last
  typedef struct packed {
    logic [3:0]        pad;
    logic              reachable;
    logic [NODE_W-1:0] node;
  } out_t;

endpackage

FILE: design/graph_reachability_engine_core.sv
// graph reachability engine: adjacency memory with a depth-first search sequencer
`timescale 1ns / 1ps
//
//  channel   | signals                           | carries
//  ----------+-----------------------------------+---------------------------------
//  s_axis    | tvalid tready tdata[7:0]          | mode, source, target
//  m_axis    | tvalid tready tdata[7:0] tlast    | node, reachable; tlast = last
//  cfg       | cfg_valid_i cfg_ready_o cfg_data_i| directed register, always ready
//
//  clear acts in idle; add edge rewrites the source row, then for an undirected
//  non-loop edge the target row (read-modify-write per row); a search scans
//  one adjacency column per cycle off the single memory read port while no
//  visit waits on m_axis, plus a pop state per stack pop; one item at a time
//  reset clears the row valid bits, so the matrix reads as empty at once
//  a stalled m_axis holds the sequencer only when a new result must be stored

module graph_reachability_engine_core #(
  parameter int unsigned NODES = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // mode [1:0], source [4:2], target [7:5]
  input  logic [gre_pkg::IN_W-1:0] s_axis_tdata,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // node [2:0], reachable [3], zeros [7:4]
  output logic [gre_pkg::OUT_W-1:0] m_axis_tdata,
  output logic                     m_axis_tlast,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic                     cfg_data_i
);

`include "graph_reachability_engine_core_defines.svh"

  localparam int unsigned NW  = $clog2(NODES);      // node index
  localparam int unsigned CW  = $clog2(NODES + 1);  // column counter, holds NODES
  localparam int unsigned SPW = $clog2(NODES + 2);  // stack pointer, holds NODES+1
  localparam int unsigned SIW = $clog2(NODES);      // stack memory index
  localparam int unsigned XW  = 7;                  // wide enough for up to 127 nodes
  localparam int unsigned FW  = NW + CW;            // stack frame

  localparam logic [NODES-1:0] ONE_HOT0 = NODES'(1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD1  = 3'd1;
  localparam logic [2:0] ST_ADD2  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_POP   = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  // memories
  logic [NODES-1:0] adj_mem [NODES];
  logic [FW-1:0]    stk_mem [NODES];

  logic             adj_we;
  logic [NW-1:0]    adj_waddr, adj_raddr;
  logic [NODES-1:0] adj_wdata, adj_rdata_q;
  logic             stk_we;
  logic [SIW-1:0]   stk_waddr, stk_raddr;
  logic [FW-1:0]    stk_wdata, stk_rdata_q;

  // control and datapath registers
  logic [2:0]       state_q, state_d;
  logic [NODES-1:0] rowv_q, rowv_d;
  logic [NODES-1:0] marks_q, marks_d;
  logic [SPW-1:0]   sp_q, sp_d;
  logic [NW-1:0]    cur_u_q, cur_u_d;
  logic [CW-1:0]    cur_j_q, cur_j_d;
  logic [NW-1:0]    pend_node_q, pend_node_d;
  logic             pend_reach_q, pend_reach_d;
  logic             directed_q;
  logic [NW-1:0]    src_q, tgt_q;
  logic             is_visit_q;

  logic             out_valid_q;
  gre_pkg::out_t    out_q;
  logic             out_last_q;
  logic             out_load;
  logic [NW-1:0]    out_node_n;
  logic             out_reach_n, out_last_n;

  // input decode
  gre_pkg::in_t     in_item;
  logic [XW-1:0]    src_x, tgt_x, onode_x;
  logic [NW-1:0]    src_n, tgt_n;
  logic             src_ok, tgt_ok;
  logic             in_xfer;

  // scan helpers
  logic [NODES-1:0] row_eff;
  logic [NW-1:0]    col_idx;
  logic             col_end, hit, push, out_free;

  assign in_item = gre_pkg::in_t'(s_axis_tdata);
  assign src_x   = XW'(in_item.source);
  assign tgt_x   = XW'(in_item.target);
  assign src_ok  = src_x < XW'(NODES);
  assign tgt_ok  = tgt_x < XW'(NODES);
  assign src_n   = src_x[NW-1:0];
  assign tgt_n   = tgt_x[NW-1:0];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign out_free      = !out_valid_q || m_axis_tready;

  // a row never written since reset or clear reads as empty
  assign row_eff = rowv_q[cur_u_q] ? adj_rdata_q : '0;
  assign col_idx = cur_j_q[NW-1:0];
  assign col_end = (cur_j_q == CW'(NODES));
  assign hit     = !col_end && row_eff[col_idx] && !marks_q[col_idx];

  // frame below the top lives at sp-1 on push, sp-2 is the new top on pop
  assign stk_waddr = SIW'(sp_q - 1'b1);
  assign stk_raddr = SIW'(sp_q - 2'd2);
  assign stk_wdata = {cur_u_q, CW'(cur_j_q + 1'b1)};

  always_comb begin
    state_d      = state_q;
    rowv_d       = rowv_q;
    marks_d      = marks_q;
    sp_d         = sp_q;
    cur_u_d      = cur_u_q;
    cur_j_d      = cur_j_q;
    pend_node_d  = pend_node_q;
    pend_reach_d = pend_reach_q;
    adj_we       = 1'b0;
    adj_waddr    = src_q;
    adj_wdata    = '0;
    stk_we       = 1'b0;
    push         = 1'b0;
    out_load     = 1'b0;
    out_node_n   = pend_node_q;
    out_reach_n  = pend_reach_q;
    out_last_n   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_item.mode)
            gre_pkg::MODE_CLEAR: begin
              rowv_d = '0;
            end
            gre_pkg::MODE_ADD: begin
              if (src_ok && tgt_ok) begin
                state_d = ST_ADD1;
              end
            end
            gre_pkg::MODE_QUERY: begin
              pend_node_d  = '0;
              pend_reach_d = 1'b0;
              if (src_ok && tgt_ok) begin
                cur_u_d = src_n;
                cur_j_d = '0;
                sp_d    = SPW'(1);
                marks_d = '0;
                state_d = ST_SCAN;
              end else begin
                state_d = ST_FLUSH;
              end
            end
            gre_pkg::MODE_VISIT: begin
              if (src_ok) begin
                pend_node_d  = src_n;
                pend_reach_d = 1'b0;
                cur_u_d      = src_n;
                cur_j_d      = '0;
                sp_d         = SPW'(1);
                marks_d      = '0;
                state_d      = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_ADD1: begin
        adj_we          = 1'b1;
        adj_waddr       = src_q;
        adj_wdata       = (rowv_q[src_q] ? adj_rdata_q : '0) | (ONE_HOT0 << tgt_q);
        rowv_d[src_q]   = 1'b1;
        // a self loop touches the same bit twice, so one write covers it
        state_d = (!directed_q && (src_q != tgt_q)) ? ST_ADD2 : ST_IDLE;
      end

      ST_ADD2: begin
        adj_we        = 1'b1;
        adj_waddr     = tgt_q;
        adj_wdata     = (rowv_q[tgt_q] ? adj_rdata_q : '0) | (ONE_HOT0 << src_q);
        rowv_d[tgt_q] = 1'b1;
        state_d       = ST_IDLE;
      end

      ST_SCAN: begin
        if (col_end) begin
          if (sp_q == SPW'(1)) begin
            state_d = ST_FLUSH;
          end else begin
            sp_d    = sp_q - 1'b1;
            state_d = ST_POP;
          end
        end else if (hit) begin
          if (!is_visit_q && (col_idx == tgt_q)) begin
            marks_d[col_idx] = 1'b1;
            pend_reach_d     = 1'b1;
            state_d          = ST_FLUSH;
          end else if (!is_visit_q || out_free) begin
            // newly reached node: mark, on a visit report the previous one, descend
            marks_d[col_idx] = 1'b1;
            push             = 1'b1;
            stk_we           = 1'b1;
            cur_u_d          = col_idx;
            cur_j_d          = '0;
            sp_d             = sp_q + 1'b1;
            if (is_visit_q) begin
              out_load    = 1'b1;
              out_last_n  = 1'b0;
              pend_node_d = col_idx;
            end
          end
        end else begin
          cur_j_d = cur_j_q + 1'b1;
        end
      end

      ST_POP: begin
        cur_u_d = stk_rdata_q[FW-1:CW];
        cur_j_d = stk_rdata_q[CW-1:0];
        state_d = ST_SCAN;
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_last_n = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // read port follows the row the next cycle needs
    if (state_q == ST_IDLE) begin
      adj_raddr = src_n;
    end else if (state_q == ST_ADD1) begin
      adj_raddr = tgt_q;
    end else begin
      adj_raddr = cur_u_d;
    end
  end

  // adjacency and stack memories, registered reads
  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_rdata_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_q <= stk_mem[stk_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rowv_q      <= '0;
      marks_q     <= '0;
      sp_q        <= '0;
      directed_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rowv_q  <= rowv_d;
      marks_q <= marks_d;
      sp_q    <= sp_d;
      if (cfg_valid_i && cfg_ready_o) begin
        directed_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_u_q      <= cur_u_d;
    cur_j_q      <= cur_j_d;
    pend_node_q  <= pend_node_d;
    pend_reach_q <= pend_reach_d;
    if (in_xfer) begin
      src_q      <= src_n;
      tgt_q      <= tgt_n;
      is_visit_q <= (in_item.mode == gre_pkg::MODE_VISIT);
    end
    if (out_load) begin
      out_q.pad       <= '0;
      out_q.reachable <= out_reach_n;
      out_q.node      <= onode_x[gre_pkg::NODE_W-1:0];
      out_last_q      <= out_last_n;
    end
  end

  assign onode_x       = XW'(out_node_n);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;

  // stack depth stays within origin plus one frame per marked node
  `GRE_ASSERT_IMP(a_sp_range, clk_i, rst_ni, state_q == ST_SCAN,
                  (sp_q != '0) && (sp_q <= SPW'(NODES + 1)))
  // column counter never runs past the end of a row
  `GRE_ASSERT_IMP(a_col_range, clk_i, rst_ni, state_q == ST_SCAN, cur_j_q <= CW'(NODES))
  // a descended-into node is marked before its row is scanned
  `GRE_ASSERT_NXT(a_push_marks, clk_i, rst_ni, push, marks_q[cur_u_q])
  // the closing result of an item always carries tlast
  `GRE_ASSERT_NXT(a_flush_last, clk_i, rst_ni, (state_q == ST_FLUSH) && out_free,
                  m_axis_tvalid && m_axis_tlast)

endmodule
